/* rtl/wslm_pkg.sv */
// Shared constants, types and word layouts for the windowed sensor limit monitor.
// Used by every module of the block but wslm_ram; depends on nothing else.
`default_nettype none

package wslm_pkg;

  localparam int SENSORS     = 10;
  localparam int WINDOW      = 5;
  localparam int SAMPLE_BITS = 16;

  localparam int SENSOR_IDX_W = 4;
  localparam int LIMIT_CFG_W  = 4;
  localparam int ROW_W        = 32;
  localparam int TOTAL_W      = 32;
  localparam int COUNT_OUT_W  = 4;
  localparam int COUNT_MAX    = 15;

  // A window sum of WINDOW samples needs log2(WINDOW) extra bits.
  localparam int SUM_W      = SAMPLE_BITS + $clog2(WINDOW);
  localparam int POS_W      = (SENSORS > 1) ? $clog2(SENSORS) : 1;
  localparam int CNT_W      = $clog2(SENSORS + 1);
  localparam int RING_DEPTH = SENSORS * WINDOW;
  localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int IN_FIELDS_W  = SENSOR_IDX_W + 3 * SAMPLE_BITS;
  localparam int S_TDATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = ROW_W + COUNT_OUT_W + TOTAL_W;
  localparam int M_TDATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  // One classified word as it travels from the front end to the back end.
  typedef struct packed {
    op_t                           op;
    logic                          last;
    logic                          fresh;
    logic [POS_W-1:0]              sensor;
    logic [RING_AW-1:0]            addr;
    logic signed [SAMPLE_BITS-1:0] lower;
    logic signed [SAMPLE_BITS-1:0] upper;
    logic signed [SAMPLE_BITS-1:0] sample;
  } item_t;

  typedef struct packed {
    logic             row_done;
    logic [CNT_W-1:0] oor_count;
  } row_info_t;

endpackage

`default_nettype wire

/* rtl/wslm_ram.sv */
// Generic single-write, single-read RAM with a registered, enabled read port.
// A read at the address being written returns the old contents. No dependencies.
`default_nettype none

module wslm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/wslm_queue.sv */
// Short register FIFO of classified words between the front end and the back end.
// Depends on wslm_pkg.
`default_nettype none

module wslm_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire wslm_pkg::item_t push_item,
  output logic                full,
  input  wire logic           pop,
  output logic                head_valid,
  output wslm_pkg::item_t     head_item
);

  wslm_pkg::item_t                  slots [wslm_pkg::QUEUE_DEPTH];
  logic [wslm_pkg::QPTR_W-1:0]      wptr;
  logic [wslm_pkg::QPTR_W-1:0]      rptr;
  logic [wslm_pkg::QCNT_W-1:0]      count;
  logic                             do_push;
  logic                             do_pop;

  assign full       = (count == wslm_pkg::QCNT_W'(wslm_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_item  = slots[rptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == wslm_pkg::QPTR_W'(wslm_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == wslm_pkg::QPTR_W'(wslm_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

/* rtl/wslm_front.sv */
// Front end: accepts input words, tracks the row position and ring address,
// drops limit loads for sensors that do not exist. Depends on wslm_pkg.
`default_nettype none

module wslm_front (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // sensor_index, lower_limit, upper_limit, sample (lowest bits first), zero padded
  input  wire logic [wslm_pkg::S_TDATA_W-1:0]   s_tdata,
  // op
  input  wire logic                             s_tuser,
  input  wire logic                             q_full,
  output logic                                  push,
  output wslm_pkg::item_t                       push_item
);

  localparam int SB = wslm_pkg::SAMPLE_BITS;
  localparam int IW = wslm_pkg::SENSOR_IDX_W;

  logic [wslm_pkg::POS_W-1:0]   pos;
  logic [wslm_pkg::RING_AW-1:0] addr;
  logic                         wrapped;

  logic [IW-1:0] idx;
  logic          accept;
  logic          is_sample;
  logic          idx_ok;
  logic          row_last;
  logic          addr_last;

  assign idx       = s_tdata[IW-1:0];
  assign s_tready  = !q_full;
  assign accept    = s_tvalid && s_tready;
  assign is_sample = (wslm_pkg::op_t'(s_tuser) == wslm_pkg::OP_SAMPLE);
  assign idx_ok    = (8'(idx) < 8'(wslm_pkg::SENSORS));
  assign row_last  = (pos == wslm_pkg::POS_W'(wslm_pkg::SENSORS - 1));
  assign addr_last = (addr == wslm_pkg::RING_AW'(wslm_pkg::RING_DEPTH - 1));

  assign push = accept && (is_sample || idx_ok);

  always_comb begin
    push_item.op     = wslm_pkg::op_t'(s_tuser);
    push_item.last   = row_last;
    // Ring entries not yet written since reset read as zero.
    push_item.fresh  = !wrapped;
    push_item.sensor = is_sample ? pos : wslm_pkg::POS_W'(idx);
    push_item.addr   = addr;
    push_item.lower  = s_tdata[IW +: SB];
    push_item.upper  = s_tdata[IW + SB +: SB];
    push_item.sample = s_tdata[IW + 2 * SB +: SB];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      addr    <= '0;
      wrapped <= 1'b0;
    end else if (accept && is_sample) begin
      pos  <= row_last ? '0 : pos + 1'b1;
      addr <= addr_last ? '0 : addr + 1'b1;
      if (addr_last) begin
        wrapped <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/wslm_back.sv */
// Back end: window sums, scaled limits and per-sensor out-of-range flags,
// with the sample ring in a RAM. Depends on wslm_pkg and wslm_ram.
`default_nettype none

module wslm_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 q_valid,
  input  wire wslm_pkg::item_t      q_item,
  output logic                      q_pop,
  input  wire logic                 rpt_ready,
  output wslm_pkg::row_info_t       info
);

  localparam int SB = wslm_pkg::SAMPLE_BITS;
  localparam int SW = wslm_pkg::SUM_W;
  localparam int CW = wslm_pkg::CNT_W;
  localparam logic signed [SW-1:0] WIN_S = SW'(wslm_pkg::WINDOW);

  wslm_pkg::item_t         b_item;
  logic                    b_valid;
  logic                    fwd_hit;
  logic signed [SB-1:0]    fwd_data;
  logic signed [SW-1:0]    sums  [wslm_pkg::SENSORS];
  logic signed [SW-1:0]    lo_w  [wslm_pkg::SENSORS];
  logic signed [SW-1:0]    hi_w  [wslm_pkg::SENSORS];
  logic [wslm_pkg::SENSORS-1:0] flags;
  logic [CW-1:0]           oor_count;

  logic                    b_fire;
  logic                    b_load;
  logic                    b_sample;
  logic [SB-1:0]           ring_rdata;
  logic signed [SB-1:0]    old_sample;
  logic signed [SW-1:0]    sum_cur;
  logic signed [SW-1:0]    sum_new;
  logic signed [SW-1:0]    lo_new;
  logic signed [SW-1:0]    hi_new;
  logic signed [SW-1:0]    cmp_sum;
  logic signed [SW-1:0]    cmp_lo;
  logic signed [SW-1:0]    cmp_hi;
  logic                    flag_new;
  logic                    flag_old;

  assign b_fire   = b_valid && rpt_ready;
  assign b_load   = q_valid && (!b_valid || b_fire);
  assign q_pop    = b_load;
  assign b_sample = (b_item.op == wslm_pkg::OP_SAMPLE);

  wslm_ram #(
    .WIDTH (SB),
    .DEPTH (wslm_pkg::RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (b_fire && b_sample),
    .waddr (b_item.addr),
    .wdata (b_item.sample),
    .re    (b_load),
    .raddr (q_item.addr),
    .rdata (ring_rdata)
  );

  always_comb begin
    if (b_item.fresh) begin
      old_sample = '0;
    end else if (fwd_hit) begin
      old_sample = fwd_data;
    end else begin
      old_sample = ring_rdata;
    end
    sum_cur = sums[b_item.sensor];
    sum_new = sum_cur + SW'(b_item.sample) - SW'(old_sample);
    lo_new  = SW'(b_item.lower) * WIN_S;
    hi_new  = SW'(b_item.upper) * WIN_S;
    if (b_sample) begin
      cmp_sum = sum_new;
      cmp_lo  = lo_w[b_item.sensor];
      cmp_hi  = hi_w[b_item.sensor];
    end else begin
      cmp_sum = sum_cur;
      cmp_lo  = lo_new;
      cmp_hi  = hi_new;
    end
    flag_new = (cmp_sum < cmp_lo) || (cmp_sum > cmp_hi);
    flag_old = flags[b_item.sensor];
  end

  assign info.row_done  = b_fire && b_sample && b_item.last;
  assign info.oor_count = oor_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      fwd_hit   <= 1'b0;
      flags     <= '0;
      oor_count <= '0;
      for (int i = 0; i < wslm_pkg::SENSORS; i++) begin
        sums[i] <= '0;
        lo_w[i] <= '0;
        hi_w[i] <= '0;
      end
    end else begin
      if (b_load) begin
        b_valid <= 1'b1;
        // The word leaving the stage writes the ring as the next one reads it.
        fwd_hit <= b_fire && b_sample && (b_item.addr == q_item.addr);
      end else if (b_fire) begin
        b_valid <= 1'b0;
      end
      if (b_fire) begin
        flags[b_item.sensor] <= flag_new;
        oor_count <= oor_count + CW'(flag_new) - CW'(flag_old);
        if (b_sample) begin
          sums[b_item.sensor] <= sum_new;
        end else begin
          lo_w[b_item.sensor] <= lo_new;
          hi_w[b_item.sensor] <= hi_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_load) begin
      b_item   <= q_item;
      fwd_data <= b_item.sample;
    end
  end

endmodule

`default_nettype wire

/* rtl/wslm_report.sv */
// Row report stage: anomaly test, row and anomaly counters, threshold register
// and the output register. Depends on wslm_pkg.
`default_nettype none

module wslm_report (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_wr_en,
  input  wire logic [wslm_pkg::LIMIT_CFG_W-1:0]    cfg_wr_data,
  input  wire wslm_pkg::row_info_t                 info,
  output logic                                     ready,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // row_number, out_of_range_count, total_anomalies (lowest bits first), zero padded
  output logic [wslm_pkg::M_TDATA_W-1:0]           m_tdata,
  // anomalous
  output logic                                     m_tuser
);

  localparam int RW = wslm_pkg::ROW_W;
  localparam int TW = wslm_pkg::TOTAL_W;
  localparam int OW = wslm_pkg::COUNT_OUT_W;

  logic [RW-1:0]                     row_counter;
  logic [TW-1:0]                     total;
  logic [wslm_pkg::LIMIT_CFG_W-1:0]  limit;
  logic                              c_valid;
  logic                              o_valid;
  logic [RW-1:0]                     o_row;
  logic [OW-1:0]                     o_count;
  logic                              o_anom;
  logic [TW-1:0]                     o_total;

  logic          c_move;
  logic          window_full;
  logic          anom;
  logic [OW-1:0] count_out;
  logic [TW-1:0] total_next;

  assign c_move = c_valid && (!o_valid || m_tready);
  // While a row end waits here the back end must hold, so that its count stays put.
  assign ready  = !c_valid || c_move;

  always_comb begin
    window_full = (row_counter >= RW'(wslm_pkg::WINDOW));
    anom        = window_full && (8'(info.oor_count) > 8'(limit));
    if (!window_full) begin
      count_out = '0;
    end else if (8'(info.oor_count) > 8'(wslm_pkg::COUNT_MAX)) begin
      count_out = OW'(wslm_pkg::COUNT_MAX);
    end else begin
      count_out = OW'(info.oor_count);
    end
    total_next = (anom && (total != '1)) ? total + 1'b1 : total;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_counter <= RW'(1);
      total       <= '0;
      limit       <= '0;
      c_valid     <= 1'b0;
      o_valid     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        limit <= cfg_wr_data;
      end
      if (info.row_done) begin
        c_valid <= 1'b1;
      end else if (c_move) begin
        c_valid <= 1'b0;
      end
      if (c_move) begin
        o_valid <= 1'b1;
        total   <= total_next;
        if (row_counter != '1) begin
          row_counter <= row_counter + 1'b1;
        end
      end else if (m_tready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (c_move) begin
      o_row   <= row_counter;
      o_count <= count_out;
      o_anom  <= anom;
      o_total <= total_next;
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = wslm_pkg::M_TDATA_W'({o_total, o_count, o_row});
  assign m_tuser  = o_anom;

endmodule

`default_nettype wire

/* rtl/windowed_sensor_limit_monitor_unit.sv */
// Windowed sensor limit monitor: one word per cycle sustained on the input stream
// while m_tready is high. The last sample of a row passes the queue, the back-end
// stage and the report stage before it shows on m_tvalid. The rate is set by the
// window-sum update, the ring RAM read ahead and its last write bypassed.
// Reset (rst, synchronous) clears sums, limits, counters and the threshold; the ring
// RAM is not swept, its first pass is tracked by a fill flag and reads as zero.
`default_nettype none

module windowed_sensor_limit_monitor_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // sensor_index, lower_limit, upper_limit, sample (lowest bits first), zero padded
  input  wire logic [wslm_pkg::S_TDATA_W-1:0]      s_tdata,
  // op
  input  wire logic                                s_tuser,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // row_number, out_of_range_count, total_anomalies (lowest bits first), zero padded
  output logic [wslm_pkg::M_TDATA_W-1:0]           m_tdata,
  // anomalous
  output logic                                     m_tuser,
  input  wire logic                                cfg_wr_en,
  input  wire logic [wslm_pkg::LIMIT_CFG_W-1:0]    cfg_wr_data
);

  wslm_pkg::item_t     push_item;
  wslm_pkg::item_t     head_item;
  wslm_pkg::row_info_t info;
  logic                push;
  logic                q_full;
  logic                head_valid;
  logic                pop;
  logic                rpt_ready;

  wslm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  wslm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  wslm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (head_valid),
    .q_item    (head_item),
    .q_pop     (pop),
    .rpt_ready (rpt_ready),
    .info      (info)
  );

  wslm_report u_report (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .info        (info),
    .ready       (rpt_ready),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
  );

endmodule

`default_nettype wire

/* verif/windowed_sensor_limit_monitor_unit_tb.sv */
// Testbench for windowed_sensor_limit_monitor_unit: drives sample and limit words and
// checks every row result against a predictor of the windowed limit test.
// Depends on rtl/wslm_pkg.sv and the unit's RTL only.
`timescale 1ns / 1ps

module windowed_sensor_limit_monitor_unit_tb;
  import wslm_pkg::*;

  typedef enum int {
    IDLE_NONE,
    IDLE_UNIFORM,
    IDLE_SPARSE
  } idle_style_t;

  typedef struct {
    op_t                           op;
    logic [SENSOR_IDX_W-1:0]       sensor_index;
    logic signed [SAMPLE_BITS-1:0] lower;
    logic signed [SAMPLE_BITS-1:0] upper;
    logic signed [SAMPLE_BITS-1:0] sample;
    int unsigned                   gap;
  } word_t;

  typedef struct {
    logic [ROW_W-1:0]       row_number;
    logic [COUNT_OUT_W-1:0] oor_count;
    logic                   anomalous;
    logic [TOTAL_W-1:0]     total;
  } row_result_t;

  localparam int SMP_MAX = 2 ** (SAMPLE_BITS - 1) - 1;
  localparam int SMP_MIN = -(2 ** (SAMPLE_BITS - 1));

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [S_TDATA_W-1:0]   s_tdata = '0;
  logic                   s_tuser = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [M_TDATA_W-1:0]   m_tdata;
  logic                   m_tuser;
  logic                   cfg_wr_en = 1'b0;
  logic [LIMIT_CFG_W-1:0] cfg_wr_data = '0;

  windowed_sensor_limit_monitor_unit DUT (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  word_t       pending_words[$];
  row_result_t expected_rows[$];
  int          mismatches = 0;
  idle_style_t tx_style = IDLE_UNIFORM;
  idle_style_t rx_style = IDLE_UNIFORM;

  // Predictor state: one history slot per row in the window, per sensor.
  int                     hist[WINDOW][SENSORS];
  int                     win_sum[SENSORS];
  int                     lower_lim[SENSORS];
  int                     upper_lim[SENSORS];
  int                     row_pos;
  int                     hist_slot;
  logic [ROW_W-1:0]       row_num;
  logic [TOTAL_W-1:0]     anomaly_total;
  logic [LIMIT_CFG_W-1:0] anomaly_limit;

  // Stimulus generator state, kept apart from the predictor.
  int lim_center[SENSORS];
  int lim_width[SENSORS];
  int gen_pos = 0;

  function automatic int unsigned draw_wait(idle_style_t style);
    case (style)
      IDLE_NONE:    return 0;
      IDLE_UNIFORM: return $urandom_range(0, 19);
      default:      return ($urandom_range(0, 5) == 0) ? $urandom_range(0, 19) : 0;
    endcase
  endfunction

  function automatic void reset_model();
    for (int s = 0; s < SENSORS; s++) begin
      for (int w = 0; w < WINDOW; w++) hist[w][s] = 0;
      win_sum[s]   = 0;
      lower_lim[s] = 0;
      upper_lim[s] = 0;
    end
    row_pos       = 0;
    hist_slot     = 0;
    row_num       = 1;
    anomaly_total = '0;
    anomaly_limit = '0;
  endfunction

  // Applies one accepted word; a word that closes a row queues its expected result.
  function automatic void predict_row_result(word_t w);
    int          cnt;
    logic        anom;
    row_result_t r;
    if (w.op == OP_LOAD) begin
      if (w.sensor_index < SENSORS) begin
        lower_lim[w.sensor_index] = int'(w.lower);
        upper_lim[w.sensor_index] = int'(w.upper);
      end
      return;
    end
    win_sum[row_pos] += int'(w.sample) - hist[hist_slot][row_pos];
    hist[hist_slot][row_pos] = int'(w.sample);
    row_pos++;
    if (row_pos < SENSORS) return;
    row_pos = 0;
    cnt     = 0;
    anom    = 1'b0;
    // The limits are scaled by the window length, so the mean is never divided out.
    if (row_num >= WINDOW) begin
      for (int s = 0; s < SENSORS; s++)
        if (win_sum[s] < lower_lim[s] * WINDOW || win_sum[s] > upper_lim[s] * WINDOW)
          cnt++;
      anom = cnt > int'(anomaly_limit);
      if (anom && anomaly_total != '1) anomaly_total++;
    end
    r.row_number = row_num;
    r.oor_count  = (cnt > COUNT_MAX) ? COUNT_OUT_W'(COUNT_MAX) : COUNT_OUT_W'(cnt);
    r.anomalous  = anom;
    r.total      = anomaly_total;
    expected_rows.push_back(r);
    if (row_num != '1) row_num++;
    hist_slot = (hist_slot + 1 >= WINDOW) ? 0 : hist_slot + 1;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < 40) $display("%0t: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_row_result();
    row_result_t exp_r;
    logic [ROW_W-1:0]       got_row;
    logic [COUNT_OUT_W-1:0] got_cnt;
    logic [TOTAL_W-1:0]     got_total;
    got_row   = m_tdata[0 +: ROW_W];
    got_cnt   = m_tdata[ROW_W +: COUNT_OUT_W];
    got_total = m_tdata[ROW_W + COUNT_OUT_W +: TOTAL_W];
    if (expected_rows.size() == 0) begin
      report_mismatch($sformatf("unexpected row result, row %0d", got_row));
      return;
    end
    exp_r = expected_rows.pop_front();
    if (got_row !== exp_r.row_number)
      report_mismatch($sformatf("row_number %0d, expected %0d", got_row, exp_r.row_number));
    if (got_cnt !== exp_r.oor_count)
      report_mismatch($sformatf("row %0d out_of_range_count %0d, expected %0d",
                                exp_r.row_number, got_cnt, exp_r.oor_count));
    if (m_tuser !== exp_r.anomalous)
      report_mismatch($sformatf("row %0d anomalous %0b, expected %0b",
                                exp_r.row_number, m_tuser, exp_r.anomalous));
    if (got_total !== exp_r.total)
      report_mismatch($sformatf("row %0d total_anomalies %0d, expected %0d",
                                exp_r.row_number, got_total, exp_r.total));
  endtask

  // Input side: each word waits its drawn gap before it is offered.
  word_t       cur_word;
  int unsigned gap_count = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid  <= 1'b0;
      gap_count <= 0;
    end else begin
      if (s_tvalid && s_tready) predict_row_result(cur_word);
      if (!s_tvalid || s_tready) begin
        if (pending_words.size() == 0) begin
          s_tvalid <= 1'b0;
        end else if (gap_count < pending_words[0].gap) begin
          gap_count <= gap_count + 1;
          s_tvalid  <= 1'b0;
        end else begin
          cur_word  = pending_words.pop_front();
          s_tdata   <= S_TDATA_W'({cur_word.sample, cur_word.upper, cur_word.lower,
                                   cur_word.sensor_index});
          s_tuser   <= cur_word.op;
          s_tvalid  <= 1'b1;
          gap_count <= 0;
        end
      end
    end
  end

  // Output side: after every accepted result, ready drops for a drawn stall, which may be zero.
  int unsigned stall_count = 0;
  int unsigned next_stall;

  always @(posedge clk) begin
    if (rst) begin
      m_tready    <= 1'b0;
      stall_count <= 0;
    end else begin
      next_stall = stall_count;
      if (m_tvalid && m_tready) begin
        check_row_result();
        next_stall = draw_wait(rx_style);
      end else if (next_stall != 0) begin
        next_stall--;
      end
      stall_count <= next_stall;
      m_tready    <= (next_stall == 0);
    end
  end

  function automatic int clamp_sample(int v);
    if (v > SMP_MAX) return SMP_MAX;
    if (v < SMP_MIN) return SMP_MIN;
    return v;
  endfunction

  function automatic void queue_word(op_t op, int idx, int lo, int hi, int smp);
    word_t w;
    w.op           = op;
    w.sensor_index = SENSOR_IDX_W'(idx);
    w.lower        = SAMPLE_BITS'(lo);
    w.upper        = SAMPLE_BITS'(hi);
    w.sample       = SAMPLE_BITS'(smp);
    w.gap          = draw_wait(tx_style);
    pending_words.push_back(w);
  endfunction

  // Unused fields of a word carry random bits so that every input bit toggles.
  function automatic void queue_load(int idx, int lo, int hi);
    queue_word(OP_LOAD, idx, lo, hi, int'($urandom));
  endfunction

  function automatic void queue_sample(int smp);
    queue_word(OP_SAMPLE, int'($urandom), int'($urandom), int'($urandom), smp);
  endfunction

  function automatic void queue_sensor_limits(int s);
    lim_center[s] = int'($urandom_range(0, 50000)) - 25000;
    lim_width[s]  = ($urandom_range(0, 7) == 0) ? 0 : int'($urandom_range(1, 3000));
    // Now and then the limits go in swapped, which puts the sensor out of range until reloaded.
    if ($urandom_range(0, 9) == 0)
      queue_load(s, clamp_sample(lim_center[s] + lim_width[s] + 1),
                 clamp_sample(lim_center[s] - lim_width[s] - 1));
    else
      queue_load(s, clamp_sample(lim_center[s] - lim_width[s]),
                 clamp_sample(lim_center[s] + lim_width[s]));
  endfunction

  task automatic wait_idle();
    @(negedge clk);
    while (pending_words.size() != 0 || s_tvalid || expected_rows.size() != 0)
      @(negedge clk);
    // Limit loads leave no result behind, so give the pipeline time to settle.
    repeat (8) @(negedge clk);
  endtask

  task automatic write_anomaly_limit(logic [LIMIT_CFG_W-1:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en     <= 1'b0;
    anomaly_limit = v;
  endtask

  // Mostly samples near each sensor's limits, with a bias toward falling outside drawn per run
  // of rows, plus occasional full-range samples, limit reloads and loads to random indices.
  task automatic run_phase(int n_words);
    int queued;
    int bad_pct;
    int rows_left;
    int v;
    int w;
    int r;
    @(negedge clk);
    queued    = 0;
    bad_pct   = 0;
    rows_left = 0;
    for (int s = 0; s < SENSORS; s++) begin
      queue_sensor_limits(s);
      queued++;
    end
    while (queued < n_words) begin
      r = $urandom_range(0, 99);
      if (r < 2) begin
        queue_load(int'($urandom_range(0, 15)), int'($urandom), int'($urandom));
      end else if (r < 4) begin
        queue_sensor_limits(int'($urandom_range(0, SENSORS - 1)));
      end else begin
        if (gen_pos == 0 && rows_left == 0) begin
          bad_pct   = $urandom_range(0, 100);
          rows_left = $urandom_range(1, 6);
        end
        w = lim_width[gen_pos];
        if (r < 7) begin
          queue_sample(int'($urandom));
        end else if (int'($urandom_range(0, 99)) < bad_pct) begin
          v = w + int'($urandom_range(1, 4000));
          queue_sample(clamp_sample(lim_center[gen_pos] + ($urandom_range(0, 1) ? v : -v)));
        end else begin
          queue_sample(clamp_sample(lim_center[gen_pos] + int'($urandom_range(0, 2 * w)) - w));
        end
        gen_pos++;
        if (gen_pos == SENSORS) begin
          gen_pos = 0;
          rows_left--;
        end
      end
      queued++;
    end
  endtask

  logic [LIMIT_CFG_W-1:0] phase_limits[8];

  initial begin
    reset_model();
    phase_limits = '{4'd15, 4'd0, 4'd10, 4'd3, 4'd1, 4'd11, 4'd5, 4'd0};
    phase_limits[7] = LIMIT_CFG_W'($urandom_range(0, 15));
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    write_anomaly_limit(4'd0);

    // Directed row: extreme limits, swapped limits, loads to sensors that do not exist,
    // a load in the middle of a row, and extreme samples. The window is not full yet.
    @(negedge clk);
    queue_load(0, SMP_MIN, SMP_MAX);
    queue_load(SENSORS - 1, SMP_MAX, SMP_MIN);
    queue_load(5, 0, 0);
    queue_load(SENSORS, 100, 200);
    queue_load(15, -1, -1);
    queue_sample(SMP_MAX);
    queue_sample(SMP_MIN);
    queue_sample(0);
    queue_sample(-1);
    queue_sample(1);
    queue_load(3, -100, 100);
    queue_sample(SMP_MIN);
    queue_sample(SMP_MAX);
    queue_sample(12345);
    queue_sample(-12345);
    queue_sample(SMP_MAX);
    wait_idle();

    for (int p = 0; p < 8; p++) begin
      write_anomaly_limit(phase_limits[p]);
      tx_style = idle_style_t'(p % 3);
      rx_style = idle_style_t'((p + 1) % 3);
      run_phase(85);
      wait_idle();
    end

    rx_style = IDLE_NONE;
    repeat (12) @(negedge clk);
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
